@@ hdl/itbl_pkg.sv @@
// ----------------------------------------------------------------------------
// itbl_pkg: shared types and constants for the inverse table interpolator
// Beat formats, table geometry and the divider request/response structs.
// ----------------------------------------------------------------------------
package itbl_pkg;

    // table geometry
    localparam int VALUE_BITS  = 52;
    localparam int TABLE_DEPTH = 256;
    localparam int ADDR_BITS   = 8;

    // entries_in_use register
    localparam int CFG_BITS = 9;
    localparam logic [CFG_BITS-1:0] CFG_RESET = 9'd200;

    // fraction bits kept from the interpolation divide, and the scaled dividend
    localparam int FRAC_OUT   = 16;
    localparam int SCALE_BITS = ADDR_BITS + FRAC_OUT;

    // item kinds
    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    typedef struct packed {
        logic                  kind;
        logic [ADDR_BITS-1:0]  entry_index;
        logic [VALUE_BITS-1:0] value;
    } t_in_beat;

    typedef struct packed {
        logic [FRAC_OUT-1:0]  porosity_q16;
        logic                 found;
        logic [ADDR_BITS-1:0] bracket_index;
    } t_out_beat;

    // divider request: fraction (num/den) then ((base<<16)+frac)/cnt
    typedef struct packed {
        logic                  start;
        logic [VALUE_BITS-1:0] num;
        logic [VALUE_BITS-1:0] den;
        logic [ADDR_BITS-1:0]  base;
        logic [CFG_BITS-1:0]   cnt;
    } t_div_req;

    typedef struct packed {
        logic                done;
        logic [FRAC_OUT-1:0] quot;
    } t_div_rsp;

endpackage

@@ hdl/itbl_ram.sv @@
// ----------------------------------------------------------------------------
// itbl_ram: generic single-clock RAM
// One write port, one read port, registered read data.
module itbl_ram #(
    parameter int DEPTH  = 256,
    parameter int WIDTH  = 52,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // read port
    always_ff @(posedge i_clk) begin
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/itbl_div.sv @@
// ----------------------------------------------------------------------------
// itbl_div: bit-serial interpolation divider
// Forms the 16-bit fraction num/den (num < den), then divides
// (base<<16 | fraction) by the entry count, one bit per cycle.
// ----------------------------------------------------------------------------
module itbl_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  itbl_pkg::t_div_req i_req,
    output itbl_pkg::t_div_rsp o_rsp
);

    localparam int STEP_BITS = $clog2(itbl_pkg::SCALE_BITS);
    localparam int VB = itbl_pkg::VALUE_BITS;
    localparam int CB = itbl_pkg::CFG_BITS;
    localparam int SB = itbl_pkg::SCALE_BITS;
    localparam int FB = itbl_pkg::FRAC_OUT;

    typedef enum logic [1:0] {
        D_IDLE,
        D_FRAC,
        D_SCALE,
        D_DONE
    } t_dstate;

    t_dstate              r_state;
    logic [STEP_BITS-1:0] r_step;
    logic [VB-1:0]        r_rem;
    logic [VB-1:0]        r_den;
    logic [FB-1:0]        r_fq;
    logic [SB-1:0]        r_dvd;
    logic [CB-1:0]        r_srem;
    logic [CB-1:0]        r_cnt;
    logic [itbl_pkg::ADDR_BITS-1:0] r_base;

    logic [VB:0]   rem2;
    logic          frac_ge;
    logic [VB:0]   rem_sub;
    logic [CB:0]   srem2;
    logic          scale_ge;
    logic [CB:0]   srem_sub;
    logic [FB-1:0] fq_next;

    // fraction step: restoring divide on the shifted remainder
    assign rem2    = {r_rem, 1'b0};
    assign frac_ge = rem2 >= {1'b0, r_den};
    assign rem_sub = rem2 - {1'b0, r_den};
    assign fq_next = {r_fq[FB-2:0], frac_ge};

    // scale step: dividend bits shift out, quotient bits shift in
    assign srem2    = {r_srem, r_dvd[SB-1]};
    assign scale_ge = srem2 >= {1'b0, r_cnt};
    assign srem_sub = srem2 - {1'b0, r_cnt};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= D_IDLE;
            r_step  <= '0;
        end else begin
            case (r_state)
                D_IDLE: begin
                    if (i_req.start) begin
                        r_rem   <= i_req.num;
                        r_den   <= i_req.den;
                        r_base  <= i_req.base;
                        r_cnt   <= i_req.cnt;
                        r_fq    <= '0;
                        r_step  <= STEP_BITS'(FB - 1);
                        r_state <= D_FRAC;
                    end
                end
                D_FRAC: begin
                    r_rem <= frac_ge ? rem_sub[VB-1:0] : rem2[VB-1:0];
                    r_fq  <= fq_next;
                    if (r_step == '0) begin
                        r_dvd   <= {r_base, fq_next};
                        r_srem  <= '0;
                        r_step  <= STEP_BITS'(SB - 1);
                        r_state <= D_SCALE;
                    end else begin
                        r_step <= r_step - 1'b1;
                    end
                end
                D_SCALE: begin
                    r_srem <= scale_ge ? srem_sub[CB-1:0] : srem2[CB-1:0];
                    r_dvd  <= {r_dvd[SB-2:0], scale_ge};
                    if (r_step == '0) begin
                        r_state <= D_DONE;
                    end else begin
                        r_step <= r_step - 1'b1;
                    end
                end
                D_DONE: begin
                    r_state <= D_IDLE;
                end
                default: begin
                    r_state <= D_IDLE;
                end
            endcase
        end
    end

    // result, saturated to the Q16 range
    assign o_rsp.done = (r_state == D_DONE);
    assign o_rsp.quot = (r_dvd[SB-1:FB] != '0) ? '1 : r_dvd[FB-1:0];

endmodule

@@ hdl/inverse_table_interpolator.sv @@
// ----------------------------------------------------------------------------
// inverse_table_interpolator: inverse lookup in a permeability table
// Loads table entries and answers queries with an interpolated Q16 porosity.
// ----------------------------------------------------------------------------
// A load beat writes one table entry and gives no result. With
// entries_in_use of 2 or more, a query beat scans the table through
// the single read port of the table RAM, one entry per cycle from
// entry 0, until the first entry above the query or the last entry in use;
// when a bracket is found and interpolation is needed, a bit-serial
// divider forms the 16-bit fraction and then scales by entries_in_use.
// A miss, or a query with entries_in_use below 2, gives a result with
// found clear. The next beat is taken only once the result has moved to
// the output register. The input stalls while a query is at work; a
// finished result waits in the output register while the next beat is
// taken. The table has no reset: entries must be loaded before a query
// reads them. entries_in_use is to be written only while the block is
// idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module inverse_table_interpolator (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  itbl_pkg::t_in_beat                  i_data,
    output logic                                o_valid,
    input  logic                                i_stall,
    output itbl_pkg::t_out_beat                 o_data,
    input  logic                                i_cfg_we,
    input  logic [itbl_pkg::CFG_BITS-1:0]       i_cfg_wdata
);

    localparam int VB = itbl_pkg::VALUE_BITS;
    localparam int AB = itbl_pkg::ADDR_BITS;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DIV,
        S_DONE
    } t_state;

    t_state                       r_state;
    logic [itbl_pkg::CFG_BITS-1:0] r_cfg;
    logic [AB-1:0]                r_chk;
    logic [AB-1:0]                r_last;
    logic [VB-1:0]                r_query;
    logic [VB-1:0]                r_lo;
    logic [VB-1:0]                r_hi;
    logic                         r_div_start;
    itbl_pkg::t_out_beat          r_res;
    logic                         r_out_valid;
    itbl_pkg::t_out_beat          r_out;

    logic                in_acc;
    logic                out_take;
    logic                ram_we;
    logic [AB-1:0]       rd_addr;
    logic [VB-1:0]       rd_data;
    itbl_pkg::t_div_req  div_req;
    itbl_pkg::t_div_rsp  div_rsp;
    logic                out_free;

    // handshakes
    assign o_stall  = (r_state != S_IDLE);
    assign in_acc   = i_valid && !o_stall;
    assign out_take = r_out_valid && !i_stall;
    assign out_free = !r_out_valid || !i_stall;

    // table RAM: loads write, the scan reads one entry ahead of r_chk
    assign ram_we  = in_acc && (i_data.kind == itbl_pkg::KIND_LOAD);
    assign rd_addr = (r_state == S_SCAN) ? r_chk + 1'b1 : '0;

    itbl_ram #(
        .DEPTH  (itbl_pkg::TABLE_DEPTH),
        .WIDTH  (VB),
        .ADDR_W (AB)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (i_data.entry_index),
        .i_wdata (i_data.value),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    // interpolation divider
    assign div_req.start = r_div_start;
    assign div_req.num   = r_query - r_lo;
    assign div_req.den   = r_hi - r_lo;
    assign div_req.base  = r_chk - 1'b1;
    assign div_req.cnt   = r_cfg;

    itbl_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= itbl_pkg::CFG_RESET;
        end else if (i_cfg_we) begin
            r_cfg <= i_cfg_wdata;
        end
    end

    // search sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_div_start <= 1'b0;
            r_chk       <= '0;
        end else begin
            r_div_start <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (in_acc && i_data.kind == itbl_pkg::KIND_QUERY) begin
                        r_query <= i_data.value;
                        r_chk   <= '0;
                        // last index searched is min(n, depth) - 1
                        r_last  <= r_cfg[AB] ? '1 : r_cfg[AB-1:0] - 1'b1;
                        if (r_cfg < itbl_pkg::CFG_BITS'(2)) begin
                            r_res   <= '0;
                            r_state <= S_DONE;
                        end else begin
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    if (r_chk == '0) begin
                        r_lo  <= rd_data;
                        r_chk <= r_chk + 1'b1;
                    end else if (rd_data > r_query) begin
                        r_hi <= rd_data;
                        if (r_query >= r_lo) begin
                            r_div_start <= 1'b1;
                            r_state     <= S_DIV;
                        end else begin
                            // query below entry 0: fraction clamps to zero
                            r_res.porosity_q16 <= '0;
                            r_res.found        <= 1'b1;
                            r_res.bracket_index <= r_chk;
                            r_state            <= S_DONE;
                        end
                    end else begin
                        r_lo <= rd_data;
                        if (r_chk == r_last) begin
                            r_res   <= '0;
                            r_state <= S_DONE;
                        end else begin
                            r_chk <= r_chk + 1'b1;
                        end
                    end
                end
                S_DIV: begin
                    if (div_rsp.done) begin
                        r_res.porosity_q16  <= div_rsp.quot;
                        r_res.found         <= 1'b1;
                        r_res.bracket_index <= r_chk;
                        r_state             <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_DONE && out_free) begin
            r_out_valid <= 1'b1;
            r_out       <= r_res;
        end else if (out_take) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule
